@@ design/skf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar Kalman filter core.
// ----------------------------------------------------------------------------
package skf_pkg;

    // default fixed point format of values
    localparam int unsigned FB_DEFAULT = 16;

    // field widths
    localparam int unsigned EST_W      = 32;
    localparam int unsigned VAR_W      = 18;
    localparam int unsigned GAIN_OUT_W = 17;
    localparam int unsigned REG_W      = 18;
    localparam int unsigned CFG_ADDR_W = 1;

    // packed stream widths
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 72;
    localparam int unsigned M_TUSER_W = 1;

    // saturation limit of the variance
    localparam logic [VAR_W-1:0] VAR_MAX = 18'h3FFFF;

    // register reset values
    localparam logic [REG_W-1:0] PROCESS_NOISE_RST     = 18'd1442;
    localparam logic [REG_W-1:0] MEASUREMENT_NOISE_RST = 18'd40436;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_NOISE     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MEASUREMENT_NOISE = 1'd1;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } skf_div_status_t;

endpackage

@@ design/skf_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_divider
// Restoring divider, one quotient bit per cycle, for the Kalman gain.
// ----------------------------------------------------------------------------
module skf_divider #(
    parameter int unsigned NUM_W = 36,
    parameter int unsigned DEN_W = 20,
    parameter int unsigned QUO_W = 17
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [NUM_W-1:0]         num,
    input  logic [DEN_W-1:0]         den,
    output logic [QUO_W-1:0]         quo,
    output skf_pkg::skf_div_status_t status
);
    import skf_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] low_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             q_bit;
    logic [DEN_W:0]   rem_next;

    // one trial subtract per cycle
    always_comb begin
        trial    = {rem_reg, low_reg[QUO_W-1]};
        q_bit    = (trial >= {1'b0, den_reg});
        rem_next = q_bit ? (trial - {1'b0, den_reg}) : trial;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(QUO_W);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    // datapath, high part of the numerator seeds the remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(num[NUM_W-1:QUO_W]);
            low_reg <= num[QUO_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next[DEN_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], q_bit};
        end
    end

    assign quo         = quo_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

@@ design/skf_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module skf_mul #(
    parameter int unsigned A_W = 18,
    parameter int unsigned B_W = 34
) (
    input  logic                     aclk,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0] p
);
    import skf_pkg::*;

    logic signed [A_W+B_W-1:0] p_reg;

    // product register
    always_ff @(posedge aclk) begin
        p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

    assign p = p_reg;

endmodule

@@ design/scalar_kalman_filter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional Kalman filter for a constant value, fixed point.
// ----------------------------------------------------------------------------
// Each input beat carries one measurement and a seed flag and gives one
// result beat with the new estimate, variance, gain and a zero-denominator
// flag. After accept the step loads the restoring divider, which produces
// one gain bit per cycle, hands the gain over, makes two passes through the
// shared multiplier and loads the output register. The result beat is valid
// in the same cycle that the input is ready again. A zero denominator skips
// the divider, and a seed beat goes straight to the output load. The input
// is not ready while a step is in progress, and a step waits at the output
// load while the previous result is not yet taken, so a stalled result side
// holds the input. The user must write the noise registers through the cfg
// port only while the block is idle; the block itself does not enforce this.
module scalar_kalman_filter_core #(
    parameter int unsigned FRACTION_BITS = skf_pkg::FB_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_we,
    input  logic [skf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [skf_pkg::REG_W-1:0]       cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [skf_pkg::S_TDATA_W-1:0]   s_tdata,  // measurement[31:0]
    input  logic [skf_pkg::S_TUSER_W-1:0]   s_tuser,  // seed[0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // estimate[31:0], variance[49:32], gain[66:50], zero pad[71:67]
    output logic [skf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [skf_pkg::M_TUSER_W-1:0]   m_tuser   // zero_denominator[0]
);
    import skf_pkg::*;

    localparam int unsigned GW   = FRACTION_BITS + 1;      // gain width
    localparam int unsigned PW   = VAR_W + 1;              // predicted variance
    localparam int unsigned DW   = VAR_W + 2;              // denominator
    localparam int unsigned NW   = FRACTION_BITS + DW;     // dividend
    localparam int unsigned DFW  = EST_W + 1;              // difference
    localparam int unsigned MA_W = GW + 1;
    localparam int unsigned MB_W = DFW + 1;
    localparam int unsigned PRW  = MA_W + MB_W;

    localparam logic [GW-1:0]  ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [PRW-1:0] HALF =
        {{(PRW-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};
    localparam logic [PRW-1:0] EST_HI = {{(PRW-EST_W){1'b0}}, 1'b0, {(EST_W-1){1'b1}}};
    localparam logic [PRW-1:0] EST_LO = {{(PRW-EST_W){1'b1}}, 1'b1, {(EST_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_MUL1,
        ST_EST,
        ST_VAR,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [REG_W-1:0]     q_reg;
    logic [REG_W-1:0]     r_reg;
    logic [EST_W-1:0]     last_est_reg;
    logic [VAR_W-1:0]     last_var_reg;
    logic [PW-1:0]        ppred_reg;
    logic [DW-1:0]        den_reg;
    logic [DFW-1:0]       diff_reg;
    logic [GW-1:0]        gain_reg;
    logic                 zden_reg;
    logic [EST_W-1:0]     est_reg;
    logic [VAR_W-1:0]     var_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic                 s_accept;
    logic                 out_free;
    logic [PW-1:0]        ppred_next;
    logic [DW-1:0]        den_next;
    logic [DFW-1:0]       diff_next;
    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [GW-1:0]        div_quo;
    skf_div_status_t      div_status;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PRW-1:0]  mul_p;
    logic signed [PRW-1:0]  est_rnd;
    logic signed [PRW-1:0]  est_sum;
    logic [PRW-1:0]       var_full;
    logic [EST_W-1:0]     est_next;
    logic [VAR_W-1:0]     var_next;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // prediction and innovation, taken from state at accept
    always_comb begin
        ppred_next = {1'b0, last_var_reg} + {1'b0, q_reg};
        den_next   = {1'b0, ppred_next} + {2'b00, r_reg};
        diff_next  = {s_tdata[EST_W-1], s_tdata[EST_W-1:0]}
                   - {last_est_reg[EST_W-1], last_est_reg};
    end

    // gain division
    assign div_start = (state_reg == ST_START) && (den_reg != '0);
    assign div_num   = {1'b0, ppred_reg, {FRACTION_BITS{1'b0}}}
                     + NW'(den_reg[DW-1:1]);

    skf_divider #(
        .NUM_W (NW),
        .DEN_W (DW),
        .QUO_W (GW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .quo     (div_quo),
        .status  (div_status)
    );

    // shared multiplier: gain times difference, then one minus gain times P'
    always_comb begin
        if (state_reg == ST_MUL1) begin
            mul_a = $signed({1'b0, gain_reg});
            mul_b = $signed({diff_reg[DFW-1], diff_reg});
        end else begin
            mul_a = $signed({1'b0, ONE - gain_reg});
            mul_b = $signed({{(MB_W-PW){1'b0}}, ppred_reg});
        end
    end

    skf_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // rounding and saturation of estimate and variance
    always_comb begin
        est_rnd  = $signed(mul_p + $signed(HALF)) >>> FRACTION_BITS;
        est_sum  = est_rnd + $signed({{(PRW-EST_W){last_est_reg[EST_W-1]}}, last_est_reg});
        var_full = ($unsigned(mul_p) + HALF) >> FRACTION_BITS;
        priority if (est_sum > $signed(EST_HI)) begin
            est_next = EST_HI[EST_W-1:0];
        end else if (est_sum < $signed(EST_LO)) begin
            est_next = EST_LO[EST_W-1:0];
        end else begin
            est_next = est_sum[EST_W-1:0];
        end
        if (var_full > PRW'(VAR_MAX)) begin
            var_next = VAR_MAX;
        end else begin
            var_next = var_full[VAR_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= PROCESS_NOISE_RST;
            r_reg <= MEASUREMENT_NOISE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_PROCESS_NOISE:     q_reg <= cfg_wdata;
                REG_MEASUREMENT_NOISE: r_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer, filter state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            last_est_reg <= '0;
            last_var_reg <= '0;
        end else begin
            // result valid: set on a new result, cleared once taken
            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        ppred_reg <= ppred_next;
                        den_reg   <= den_next;
                        diff_reg  <= diff_next;
                        zden_reg  <= 1'b0;
                        if (s_tuser[0]) begin
                            est_reg   <= s_tdata[EST_W-1:0];
                            var_reg   <= '0;
                            gain_reg  <= ONE;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_START;
                        end
                    end
                end
                ST_START: begin
                    if (den_reg == '0) begin
                        gain_reg  <= '0;
                        zden_reg  <= 1'b1;
                        state_reg <= ST_MUL1;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        gain_reg  <= (div_quo > ONE) ? ONE : div_quo;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    state_reg <= ST_EST;
                end
                ST_EST: begin
                    est_reg   <= est_next;
                    state_reg <= ST_VAR;
                end
                ST_VAR: begin
                    var_reg   <= var_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {{(M_TDATA_W-EST_W-VAR_W-GAIN_OUT_W){1'b0}},
                                         GAIN_OUT_W'(gain_reg), var_reg, est_reg};
                        m_tuser_reg  <= zden_reg;
                        last_est_reg <= est_reg;
                        last_var_reg <= var_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // gain never above one once it is taken from the divider
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL1) |-> (gain_reg <= ONE))
        else $error("gain above one");

    // zero denominator leaves no gain and no variance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
        (m_tdata[EST_W+VAR_W-1:EST_W] == '0
         && m_tdata[EST_W+VAR_W+GAIN_OUT_W-1:EST_W+VAR_W] == '0))
        else $error("zero denominator with nonzero gain or variance");

    // the divider only runs while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside the division state");

    // an accepted beat closes the input until its result is out
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input ready right after accept");

endmodule
